### rtl/oakt_pkg.sv
package oakt_pkg;

	localparam int INDEX_BITS_DEF = 10;
	localparam int KEY_BYTES_DEF  = 8;

	localparam logic [63:0] HASH_MUL = 64'd1111111111111111111;
	localparam logic [7:0]  BYTE_MASK = 8'd255;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_LOOKUP = 2'd2,
		ACT_OTHER  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		MARK_EMPTY = 2'd0,
		MARK_USED  = 2'd1,
		MARK_TOMB  = 2'd2,
		MARK_RSVD  = 2'd3
	} mark_t;

	typedef enum logic [2:0] {
		ST_FOUND    = 3'd0,
		ST_INSERTED = 3'd1,
		ST_REMOVED  = 3'd2,
		ST_ABSENT   = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [63:0] key;
		logic [3:0]  len;
		logic [63:0] hash;
	} req_t;

endpackage

### rtl/oakt_ram.sv
module oakt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

### rtl/oakt_front.sv
module oakt_front
	import oakt_pkg::*;
#(
	parameter int KEY_BYTES = KEY_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  in_action,
	input  logic [63:0] in_key,
	input  logic [3:0]  in_len,
	output logic        push,
	input  logic        push_ready,
	output req_t        req
);
	typedef enum logic [4:0] {
		F_IDLE = 5'b00001,
		F_P0   = 5'b00010,
		F_P1   = 5'b00100,
		F_P2   = 5'b01000,
		F_PUSH = 5'b10000
	} fstate_t;

	localparam logic [3:0] KB = 4'(KEY_BYTES);

	fstate_t     state_q;
	logic [1:0]  action_q;
	logic [63:0] key_q, rest_q, x_q, h_q, p0_q;
	logic [31:0] acc_q;
	logic [3:0]  len_q, cnt_q;
	logic [3:0]  len_sat;
	logic [63:0] trim;
	logic [31:0] mid;
	logic [63:0] h_next;

	always_comb begin
		len_sat = (in_len > KB) ? KB : in_len;
		for (int b = 0; b < 8; b++)
			trim[8*b +: 8] = (4'(b) < len_sat) ? in_key[8*b +: 8] : 8'd0;
	end

	assign mid    = acc_q + 32'(x_q[63:32] * HASH_MUL[31:0]);
	assign h_next = p0_q + {mid, 32'd0};

	assign in_ready = (state_q == F_IDLE);
	assign push     = (state_q == F_PUSH);
	assign req      = '{action: action_q, key: key_q, len: len_q, hash: h_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						action_q <= in_action;
						key_q    <= trim;
						len_q    <= len_sat;
						h_q      <= 64'd0;
						x_q      <= {56'd0, trim[7:0] & BYTE_MASK};
						rest_q   <= trim >> 8;
						cnt_q    <= len_sat - 4'd1;
						state_q  <= (len_sat == 4'd0) ? F_PUSH : F_P0;
					end
				end
				F_P0: begin
					p0_q    <= x_q[31:0] * HASH_MUL[31:0];
					state_q <= F_P1;
				end
				F_P1: begin
					acc_q   <= 32'(x_q[31:0] * HASH_MUL[63:32]);
					state_q <= F_P2;
				end
				F_P2: begin
					h_q <= h_next;
					if (cnt_q == 4'd0) begin
						state_q <= F_PUSH;
					end else begin
						x_q     <= h_next ^ {56'd0, rest_q[7:0]};
						rest_q  <= rest_q >> 8;
						cnt_q   <= cnt_q - 4'd1;
						state_q <= F_P0;
					end
				end
				F_PUSH: begin
					if (push_ready)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule

### rtl/oakt_queue.sv
module oakt_queue
	import oakt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic push_ready,
	input  req_t push_data,
	output logic pop_valid,
	input  logic pop,
	output req_t pop_data
);
	req_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push)
				wr_q <= ~wr_q;
			if (do_pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end
endmodule

### rtl/oakt_back.sv
module oakt_back
	import oakt_pkg::*;
#(
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	output logic       q_pop,
	input  req_t       q_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] out_status,
	output logic [9:0] out_slot
);
	typedef enum logic [3:0] {
		B_CLR  = 4'b0001,
		B_IDLE = 4'b0010,
		B_RD   = 4'b0100,
		B_EV   = 4'b1000
	} bstate_t;

	localparam int IB = INDEX_BITS;
	localparam logic [IB:0] HALF    = {2'b01, {(IB-1){1'b0}}};
	localparam logic [IB:0] LAST_N  = {1'b0, {IB{1'b1}}};

	bstate_t       state_q;
	req_t          r_q;
	logic [IB-1:0] idx_q, step_q, tomb_q, fresh_q;
	logic [IB:0]   n_q, clr_q;
	logic          have_tomb_q;
	logic          ovalid_q;
	logic [2:0]    ostatus_q;
	logic [9:0]    oslot_q;

	logic [IB-1:0] addr, wr_addr, step_in;
	logic          mark_we, key_we;
	logic [1:0]    mark_wdata, mark_rd;
	logic [67:0]   kl_rd;
	logic          finish, fresh_inc, tomb_eff;
	logic [IB-1:0] tomb_at;
	status_t       st;
	logic [IB-1:0] slot_idx;
	logic [IB+9:0] slot_ext;

	oakt_ram #(.WIDTH(2), .DEPTH(2**IB)) u_mark (
		.clk(clk), .we(mark_we), .addr(addr), .wdata(mark_wdata), .rdata(mark_rd)
	);
	oakt_ram #(.WIDTH(68), .DEPTH(2**IB)) u_key (
		.clk(clk), .we(key_we), .addr(addr), .wdata({r_q.len, r_q.key}), .rdata(kl_rd)
	);

	assign step_in = q_data.hash[63 -: IB] | IB'(1);

	always_comb begin
		mark_we    = 1'b0;
		key_we     = 1'b0;
		mark_wdata = MARK_EMPTY;
		wr_addr    = idx_q;
		finish     = 1'b0;
		fresh_inc  = 1'b0;
		st         = ST_ABSENT;
		slot_idx   = '0;
		tomb_eff   = have_tomb_q || (mark_rd == MARK_TOMB);
		tomb_at    = have_tomb_q ? tomb_q : idx_q;
		if (state_q == B_CLR) begin
			mark_we = 1'b1;
		end else if (state_q == B_EV) begin
			priority if (mark_rd == MARK_EMPTY) begin
				finish = 1'b1;
				if (r_q.action == ACT_INSERT) begin
					if (({1'b0, fresh_q} + (IB+1)'(1)) >= HALF) begin
						st = ST_FULL;
					end else begin
						wr_addr    = tomb_at;
						mark_we    = 1'b1;
						key_we     = 1'b1;
						mark_wdata = MARK_USED;
						fresh_inc  = !have_tomb_q;
						st         = ST_INSERTED;
						slot_idx   = tomb_at;
					end
				end
			end else if (mark_rd == MARK_USED && kl_rd == {r_q.len, r_q.key}) begin
				finish   = 1'b1;
				slot_idx = idx_q;
				if (r_q.action == ACT_DELETE) begin
					mark_we    = 1'b1;
					mark_wdata = MARK_TOMB;
					st         = ST_REMOVED;
				end else begin
					st = ST_FOUND;
				end
			end else if (n_q == LAST_N) begin
				finish = 1'b1;
				if (r_q.action == ACT_INSERT && tomb_eff) begin
					wr_addr    = tomb_at;
					mark_we    = 1'b1;
					key_we     = 1'b1;
					mark_wdata = MARK_USED;
					st         = ST_INSERTED;
					slot_idx   = tomb_at;
				end else begin
					st = (r_q.action == ACT_INSERT) ? ST_FULL : ST_ABSENT;
				end
			end
		end
		unique case (state_q)
			B_CLR:   addr = clr_q[IB-1:0];
			B_EV:    addr = wr_addr;
			default: addr = idx_q;
		endcase
	end

	assign slot_ext   = {10'd0, slot_idx};
	assign q_pop      = (state_q == B_IDLE) && q_valid && !ovalid_q;
	assign out_valid  = ovalid_q;
	assign out_status = ostatus_q;
	assign out_slot   = oslot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_CLR;
			clr_q    <= '0;
			fresh_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && out_ready)
				ovalid_q <= 1'b0;
			unique case (state_q)
				B_CLR: begin
					clr_q <= clr_q + (IB+1)'(1);
					if (clr_q[IB-1:0] == {IB{1'b1}})
						state_q <= B_IDLE;
				end
				B_IDLE: begin
					if (q_pop) begin
						r_q         <= q_data;
						step_q      <= step_in;
						idx_q       <= q_data.hash[IB-1:0] + step_in;
						n_q         <= '0;
						have_tomb_q <= 1'b0;
						state_q     <= B_RD;
					end
				end
				B_RD: state_q <= B_EV;
				B_EV: begin
					if (mark_rd == MARK_TOMB && !have_tomb_q) begin
						have_tomb_q <= 1'b1;
						tomb_q      <= idx_q;
					end
					if (finish) begin
						if (fresh_inc)
							fresh_q <= fresh_q + IB'(1);
						ovalid_q  <= 1'b1;
						ostatus_q <= st;
						oslot_q   <= slot_ext[9:0];
						state_q   <= B_IDLE;
					end else begin
						idx_q   <= idx_q + step_q;
						n_q     <= n_q + (IB+1)'(1);
						state_q <= B_RD;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule

### rtl/open_addressed_key_table_unit.sv
// Path: the front hashes each key byte in states P0, P1 and P2, the back spends a read
// state and an evaluate state on each probe, and the queue and output register lie between.
// Overlap: the front hashes the next key while the back probes the single-port slot
// memories; each side takes a new request only once it is done with the last one.
// Reset: asynchronous, active low; the back then clears the slot marks before it takes
// a request, while the front already accepts and hashes.
module open_addressed_key_table_unit
	import oakt_pkg::*;
#(
	parameter int INDEX_BITS = INDEX_BITS_DEF,
	parameter int KEY_BYTES  = KEY_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // action[1:0], key_bytes[65:2], key_len[69:66]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // status[2:0], slot[12:3]
);
	logic       push, push_ready, q_valid, q_pop;
	req_t       req, q_data;
	logic [2:0] status;
	logic [9:0] slot;

	oakt_front #(.KEY_BYTES(KEY_BYTES)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_action(s_axis_tdata[1:0]), .in_key(s_axis_tdata[65:2]),
		.in_len(s_axis_tdata[69:66]),
		.push(push), .push_ready(push_ready), .req(req)
	);

	oakt_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_ready(push_ready), .push_data(req),
		.pop_valid(q_valid), .pop(q_pop), .pop_data(q_data)
	);

	oakt_back #(.INDEX_BITS(INDEX_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_status(status), .out_slot(slot)
	);

	assign m_axis_tdata = {3'd0, slot, status};
endmodule

### rtl/oakt_checker.sv
module oakt_checker
	import oakt_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [71:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[2:0] <= ST_FULL))
		else $error("status code out of range");

	a_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[2:0] == ST_ABSENT || m_axis_tdata[2:0] == ST_FULL)
		|-> m_axis_tdata[12:3] == 10'd0)
		else $error("slot set on absent or full");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[15:13] == 3'd0)
		else $error("padding bits set");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped while stalled");
endmodule

bind open_addressed_key_table_unit oakt_checker u_oakt_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.s_axis_tdata(s_axis_tdata),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);
